/* sv/qvr_pkg.sv */
// Shared constants for the quaternion vector rotation pipeline.
`default_nettype none

package qvr_pkg;

   // Unit quaternion components are carried in Q.30
   localparam int UNIT_FRAC  = 30;
   // Quotient bits of |q_i| * 2^30 / |q|; the quotient never exceeds 2^30
   localparam int QUO_BITS   = UNIT_FRAC + 1;
   // Signed width of one unit quaternion component
   localparam int UNIT_WIDTH = UNIT_FRAC + 2;

endpackage

`default_nettype wire

/* sv/qvr_norm.sv */
// Quaternion length (pipelined square root) and normalization (pipelined dividers).
`default_nettype none

module qvr_norm import qvr_pkg::*; #(
   parameter int COMP_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [COMP_WIDTH-1:0]        vec_in [3],
   input  logic [COMP_WIDTH-1:0]        quat_in [4],
   output logic                         out_valid,
   output logic [COMP_WIDTH:0]          len_out,
   output logic signed [UNIT_WIDTH-1:0] unit_out [4],
   output logic [COMP_WIDTH-1:0]        vec_out [3]
);

   localparam int W  = COMP_WIDTH;
   localparam int NS = W + 1;       // root bits, one per stage
   localparam int RW = W + 4;       // square root partial remainder
   localparam int DW = W + 2;       // divider partial remainder
   localparam int SW = 2 * W + 1;   // exact sum of four squares

   typedef struct packed {
      logic                  valid;
      logic [3:0][2*W-1:0]   sq;
      logic [3:0][W-1:0]     qmag;
      logic [3:0]            qneg;
      logic [2:0][W-1:0]     vec;
   } sqr_type;

   typedef struct packed {
      logic                  valid;
      logic [RW-1:0]         rem;
      logic [W:0]            root;
      logic [2*W+1:0]        rad;
      logic [3:0][W-1:0]     qmag;
      logic [3:0]            qneg;
      logic [2:0][W-1:0]     vec;
   } root_stage_type;

   typedef struct packed {
      logic                       valid;
      logic [W:0]                 len;
      logic [3:0][DW-1:0]         rem;
      logic [3:0][QUO_BITS-1:0]   quo;
      logic [3:0][QUO_BITS-1:0]   nb;
      logic [3:0]                 qneg;
      logic [2:0][W-1:0]          vec;
   } div_stage_type;

   sqr_type        n1_in, n1_ff;
   root_stage_type sq_in0;
   root_stage_type sq_ff [NS+1];
   div_stage_type  dv_init;
   div_stage_type  dv_ff [QUO_BITS];
   logic [SW-1:0]  sum;

   // squares of the component magnitudes
   always_comb begin
      n1_in.valid = in_valid;
      for (int i = 0; i < 4; i++) begin
         n1_in.qneg[i] = quat_in[i][W-1];
         n1_in.qmag[i] = quat_in[i][W-1] ? W'(-quat_in[i]) : quat_in[i];
         n1_in.sq[i]   = {{W{1'b0}}, n1_in.qmag[i]} * {{W{1'b0}}, n1_in.qmag[i]};
      end
      for (int i = 0; i < 3; i++) begin
         n1_in.vec[i] = vec_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_ff.valid <= 1'b0;
      end else if (en) begin
         n1_ff <= n1_in;
      end
   end

   always_comb begin
      sum = {1'b0, n1_ff.sq[0]} + {1'b0, n1_ff.sq[1]}
          + {1'b0, n1_ff.sq[2]} + {1'b0, n1_ff.sq[3]};
      sq_in0.valid = n1_ff.valid;
      sq_in0.rem   = '0;
      sq_in0.root  = '0;
      sq_in0.rad   = {1'b0, sum};
      sq_in0.qmag  = n1_ff.qmag;
      sq_in0.qneg  = n1_ff.qneg;
      sq_in0.vec   = n1_ff.vec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0].valid <= 1'b0;
      end else if (en) begin
         sq_ff[0] <= sq_in0;
      end
   end

   // restoring square root, two radicand bits per stage
   for (genvar k = 0; k < NS; k++) begin : g_root
      logic [RW-1:0]  remsh;
      logic [RW-1:0]  test;
      logic           ge;
      root_stage_type nxt;

      always_comb begin
         remsh    = {sq_ff[k].rem[RW-3:0], sq_ff[k].rad[2*W+1:2*W]};
         test     = {1'b0, sq_ff[k].root, 2'b01};
         ge       = remsh >= test;
         nxt      = sq_ff[k];
         nxt.rem  = ge ? remsh - test : remsh;
         nxt.root = {sq_ff[k].root[W-1:0], ge};
         nxt.rad  = {sq_ff[k].rad[2*W-1:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            sq_ff[k+1] <= nxt;
         end
      end
   end

   always_comb begin
      dv_init.valid = sq_ff[NS].valid;
      dv_init.len   = sq_ff[NS].root;
      dv_init.qneg  = sq_ff[NS].qneg;
      dv_init.vec   = sq_ff[NS].vec;
      for (int i = 0; i < 4; i++) begin
         dv_init.rem[i] = {3'b000, sq_ff[NS].qmag[i][W-1:1]};
         dv_init.quo[i] = '0;
         dv_init.nb[i]  = {sq_ff[NS].qmag[i][0], {UNIT_FRAC{1'b0}}};
      end
   end

   // four parallel restoring dividers, one quotient bit per stage
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      div_stage_type cur;
      div_stage_type nxt;
      logic [DW-1:0] remsh [4];
      logic [DW-1:0] lenx;
      logic [3:0]    ge;

      if (k == 0) begin : g_first
         assign cur = dv_init;
      end else begin : g_next
         assign cur = dv_ff[k-1];
      end

      always_comb begin
         nxt  = cur;
         lenx = {1'b0, cur.len};
         for (int i = 0; i < 4; i++) begin
            remsh[i]   = {cur.rem[i][DW-2:0], cur.nb[i][QUO_BITS-1]};
            ge[i]      = remsh[i] >= lenx;
            nxt.rem[i] = ge[i] ? remsh[i] - lenx : remsh[i];
            nxt.quo[i] = {cur.quo[i][QUO_BITS-2:0], ge[i]};
            nxt.nb[i]  = {cur.nb[i][QUO_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].valid <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= nxt;
         end
      end
   end

   // zero length only for the all-zero quaternion: unit forced to zero
   always_comb begin
      out_valid = dv_ff[QUO_BITS-1].valid;
      len_out   = dv_ff[QUO_BITS-1].len;
      for (int i = 0; i < 4; i++) begin
         if (dv_ff[QUO_BITS-1].len == '0) begin
            unit_out[i] = '0;
         end else if (dv_ff[QUO_BITS-1].qneg[i]) begin
            unit_out[i] = -UNIT_WIDTH'(dv_ff[QUO_BITS-1].quo[i]);
         end else begin
            unit_out[i] = UNIT_WIDTH'(dv_ff[QUO_BITS-1].quo[i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         vec_out[i] = dv_ff[QUO_BITS-1].vec[i];
      end
   end

endmodule

`default_nettype wire

/* sv/quaternion_vector_rotate.sv */
// Top level: rotates a vector by a quaternion and scales it by the quaternion length.
`default_nettype none

// Rotates (vec_x, vec_y, vec_z) by the quaternion (quat_x, quat_y, quat_z, quat_w)
// and scales the result by |q|; all values are signed fixed point with FRAC_BITS
// fraction bits. A zero quaternion gives a zero vector. Each component of the
// result is clamped to the signed COMP_WIDTH range and rsp_saturated flags any
// clamp. The pipeline takes one item per cycle while the output is not stalled;
// the square root is bit-per-stage (COMP_WIDTH + 1 stages) and so are the
// normalizing dividers (31 stages). When the output is stalled the whole pipeline
// holds.
module quaternion_vector_rotate import qvr_pkg::*; #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COMP_WIDTH-1:0] req_vec_x,
   input  logic signed [COMP_WIDTH-1:0] req_vec_y,
   input  logic signed [COMP_WIDTH-1:0] req_vec_z,
   input  logic signed [COMP_WIDTH-1:0] req_quat_x,
   input  logic signed [COMP_WIDTH-1:0] req_quat_y,
   input  logic signed [COMP_WIDTH-1:0] req_quat_z,
   input  logic signed [COMP_WIDTH-1:0] req_quat_w,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_x,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_y,
   output logic signed [COMP_WIDTH-1:0] rsp_rot_z,
   output logic                         rsp_saturated
);

   localparam int W   = COMP_WIDTH;
   localparam int UW  = UNIT_WIDTH;
   localparam int TW  = W + 4;          // intermediate quaternion components
   localparam int PW1 = UW + W;         // unit * vector product
   localparam int PW2 = TW + UW;        // intermediate * conjugate product
   localparam int SW2 = PW2 + 2;        // exact sum of up to four products
   localparam int MW  = TW + W + 1;     // magnitude * length
   localparam int RSW = MW + 1;

   localparam logic signed [W-1:0]  POS_MAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  NEG_MAX  = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [UW-1:0] UNIT_ONE = UW'(1) << UNIT_FRAC;

   // divide by 2^30, nearest with ties away from zero
   function automatic logic signed [TW-1:0] round_q30(input logic signed [SW2-1:0] s);
      logic [SW2-1:0] mag;
      logic [SW2-1:0] rm;
      mag = s[SW2-1] ? SW2'(-s) : SW2'(s);
      rm  = (mag + (SW2'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      return s[SW2-1] ? TW'(-rm) : TW'(rm);
   endfunction

   logic                  adv;
   logic [W-1:0]          vec_bus [3];
   logic [W-1:0]          quat_bus [4];
   logic                  n_valid;
   logic [W:0]            n_len;
   logic signed [UW-1:0]  n_unit [4];
   logic [W-1:0]          n_vec [3];
   logic signed [W-1:0]   vs [3];

   logic                  p1_valid_ff;
   logic signed [PW1-1:0] p1_prod_in [4][3];
   logic signed [PW1-1:0] p1_prod_ff [4][3];
   logic [W:0]            p1_len_ff;
   logic signed [UW-1:0]  p1_unit_ff [4];

   logic                  p2_valid_ff;
   logic signed [SW2-1:0] p2_sum [4];
   logic signed [TW-1:0]  p2_t_ff [4];
   logic [W:0]            p2_len_ff;
   logic signed [UW-1:0]  p2_unit_ff [4];

   logic signed [UW-1:0]  cj [4];
   logic                  p3_valid_ff;
   logic signed [PW2-1:0] p3_prod_in [3][4];
   logic signed [PW2-1:0] p3_prod_ff [3][4];
   logic [W:0]            p3_len_ff;

   logic                  p4_valid_ff;
   logic signed [SW2-1:0] p4_sum [3];
   logic signed [TW-1:0]  p4_r_ff [3];
   logic [W:0]            p4_len_ff;

   logic                  p5_valid_ff;
   logic [TW-1:0]         p5_mag [3];
   logic [MW-1:0]         p5_prod_ff [3];
   logic [2:0]            p5_neg_ff;

   logic [RSW-1:0]        res [3];
   logic [RSW-1:0]        lim [3];
   logic [2:0]            over;
   logic [W-1:0]          clamp [3];
   logic signed [W-1:0]   rot_in [3];
   logic signed [W-1:0]   rot_ff [3];
   logic                  rsp_valid_ff;
   logic                  rsp_sat_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign vec_bus  = '{req_vec_x, req_vec_y, req_vec_z};
   assign quat_bus = '{req_quat_x, req_quat_y, req_quat_z, req_quat_w};

   qvr_norm #(
      .COMP_WIDTH(COMP_WIDTH)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .vec_in   (vec_bus),
      .quat_in  (quat_bus),
      .out_valid(n_valid),
      .len_out  (n_len),
      .unit_out (n_unit),
      .vec_out  (n_vec)
   );

   // t = u * (v, 0)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vs[i] = $signed(n_vec[i]);
      end
      p1_prod_in[0][0] = n_unit[3] * vs[0];
      p1_prod_in[0][1] = n_unit[1] * vs[2];
      p1_prod_in[0][2] = n_unit[2] * vs[1];
      p1_prod_in[1][0] = n_unit[3] * vs[1];
      p1_prod_in[1][1] = n_unit[2] * vs[0];
      p1_prod_in[1][2] = n_unit[0] * vs[2];
      p1_prod_in[2][0] = n_unit[3] * vs[2];
      p1_prod_in[2][1] = n_unit[0] * vs[1];
      p1_prod_in[2][2] = n_unit[1] * vs[0];
      p1_prod_in[3][0] = n_unit[0] * vs[0];
      p1_prod_in[3][1] = n_unit[1] * vs[1];
      p1_prod_in[3][2] = n_unit[2] * vs[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= n_valid;
         p1_prod_ff  <= p1_prod_in;
         p1_len_ff   <= n_len;
         p1_unit_ff  <= n_unit;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p2_sum[j] = SW2'(p1_prod_ff[j][0]) + SW2'(p1_prod_ff[j][1])
                   - SW2'(p1_prod_ff[j][2]);
      end
      p2_sum[3] = -SW2'(p1_prod_ff[3][0]) - SW2'(p1_prod_ff[3][1])
                - SW2'(p1_prod_ff[3][2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
         for (int j = 0; j < 4; j++) begin
            p2_t_ff[j] <= round_q30(p2_sum[j]);
         end
         p2_len_ff  <= p1_len_ff;
         p2_unit_ff <= p1_unit_ff;
      end
   end

   // r = t * conj(u), vector part only
   always_comb begin
      cj[0] = -p2_unit_ff[0];
      cj[1] = -p2_unit_ff[1];
      cj[2] = -p2_unit_ff[2];
      cj[3] = p2_unit_ff[3];
      p3_prod_in[0][0] = p2_t_ff[0] * cj[3];
      p3_prod_in[0][1] = p2_t_ff[3] * cj[0];
      p3_prod_in[0][2] = p2_t_ff[1] * cj[2];
      p3_prod_in[0][3] = p2_t_ff[2] * cj[1];
      p3_prod_in[1][0] = p2_t_ff[1] * cj[3];
      p3_prod_in[1][1] = p2_t_ff[3] * cj[1];
      p3_prod_in[1][2] = p2_t_ff[2] * cj[0];
      p3_prod_in[1][3] = p2_t_ff[0] * cj[2];
      p3_prod_in[2][0] = p2_t_ff[2] * cj[3];
      p3_prod_in[2][1] = p2_t_ff[3] * cj[2];
      p3_prod_in[2][2] = p2_t_ff[0] * cj[1];
      p3_prod_in[2][3] = p2_t_ff[1] * cj[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
         p3_prod_ff  <= p3_prod_in;
         p3_len_ff   <= p2_len_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p4_sum[j] = SW2'(p3_prod_ff[j][0]) + SW2'(p3_prod_ff[j][1])
                   + SW2'(p3_prod_ff[j][2]) - SW2'(p3_prod_ff[j][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= p3_valid_ff;
         for (int j = 0; j < 3; j++) begin
            p4_r_ff[j] <= round_q30(p4_sum[j]);
         end
         p4_len_ff <= p3_len_ff;
      end
   end

   // scale the magnitude by the length
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p5_mag[j] = p4_r_ff[j][TW-1] ? TW'(-p4_r_ff[j]) : TW'(p4_r_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p5_valid_ff <= p4_valid_ff;
         for (int j = 0; j < 3; j++) begin
            p5_prod_ff[j] <= MW'(p5_mag[j]) * MW'(p4_len_ff);
            p5_neg_ff[j]  <= p4_r_ff[j][TW-1];
         end
      end
   end

   // round, clamp to the signed component range, restore sign
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         res[j]   = (RSW'(p5_prod_ff[j]) + (RSW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         lim[j]   = p5_neg_ff[j] ? (RSW'(1) << (W - 1)) : ((RSW'(1) << (W - 1)) - 1'b1);
         over[j]  = res[j] > lim[j];
         clamp[j] = over[j] ? lim[j][W-1:0] : res[j][W-1:0];
         rot_in[j] = p5_neg_ff[j] ? -clamp[j] : clamp[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p5_valid_ff;
         rot_ff       <= rot_in;
         rsp_sat_ff   <= |over;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_zero_len_unit: assert property (@(posedge clock) disable iff (reset)
      n_valid && n_len == '0 |->
         n_unit[0] == '0 && n_unit[1] == '0 && n_unit[2] == '0 && n_unit[3] == '0)
      else $error("unit quaternion not zero for zero length");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      n_valid |->
         n_unit[0] <= UNIT_ONE && n_unit[0] >= -UNIT_ONE &&
         n_unit[1] <= UNIT_ONE && n_unit[1] >= -UNIT_ONE &&
         n_unit[2] <= UNIT_ONE && n_unit[2] >= -UNIT_ONE &&
         n_unit[3] <= UNIT_ONE && n_unit[3] >= -UNIT_ONE)
      else $error("unit quaternion component above one");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |->
         rot_ff[0] == POS_MAX || rot_ff[0] == NEG_MAX ||
         rot_ff[1] == POS_MAX || rot_ff[1] == NEG_MAX ||
         rot_ff[2] == POS_MAX || rot_ff[2] == NEG_MAX)
      else $error("saturated item has no clamped component");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for quaternion_vector_rotate: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module testbench import qvr_pkg::*; ();

   typedef struct {
      logic signed [31:0] vx, vy, vz;
      logic signed [31:0] qx, qy, qz, qw;
      bit                 drain;   // hold this item until the pipeline is empty
   } rot_req_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      bit                 sat;
   } rot_rsp_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = 72;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic signed [31:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_saturated;

   rot_req_type pending_items[$];
   rot_rsp_type expected_rots[$];
   rot_req_type cur_item;
   bit       items_loaded = 0;
   int       errors = 0;
   int       cycles = 0;
   int       burst_left = 0, gap_left = 0;
   int       stall_mode = 0;

   quaternion_vector_rotate dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .req_quat_w(req_quat_w),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rot_x(rsp_rot_x), .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // x / 2^30, nearest, ties away from zero; x is a 64-bit two's complement pattern
   function automatic longint round_unit(logic [63:0] x);
      logic        neg;
      logic [63:0] mag;
      neg = x[63];
      mag = neg ? (~x + 64'd1) : x;
      mag = (mag + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic rot_rsp_type predict_rotation(rot_req_type it);
      longint      v[3], q[4], u[4], t[4], c[4], r[3];
      logic [64:0] sumsq;
      logic [63:0] len, mag, quo, res, lim;
      logic [63:0] half;
      logic        neg, over;
      logic [31:0] outv[3];
      rot_rsp_type p;
      half = 64'd1 << 15;
      v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
      q[0] = it.qx; q[1] = it.qy; q[2] = it.qz; q[3] = it.qw;
      sumsq = 0;
      for (int i = 0; i < 4; i++) sumsq = sumsq + 65'(q[i] * q[i]);
      len = sumsq[64] ? (64'd1 << 32) : floor_sqrt(sumsq[63:0]);
      for (int i = 0; i < 4; i++) begin
         if (len == 0) begin
            u[i] = 0;
         end else begin
            mag = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
            quo = (mag << UNIT_FRAC) / len;
            u[i] = (q[i] < 0) ? -longint'(quo) : longint'(quo);
         end
      end
      t[0] = round_unit(u[3]*v[0] + u[1]*v[2] - u[2]*v[1]);
      t[1] = round_unit(u[3]*v[1] + u[2]*v[0] - u[0]*v[2]);
      t[2] = round_unit(u[3]*v[2] + u[0]*v[1] - u[1]*v[0]);
      t[3] = round_unit(64'sd0 - u[0]*v[0] - u[1]*v[1] - u[2]*v[2]);
      c[0] = -u[0]; c[1] = -u[1]; c[2] = -u[2]; c[3] = u[3];
      r[0] = round_unit(t[0]*c[3] + t[3]*c[0] + t[1]*c[2] - t[2]*c[1]);
      r[1] = round_unit(t[1]*c[3] + t[3]*c[1] + t[2]*c[0] - t[0]*c[2]);
      r[2] = round_unit(t[2]*c[3] + t[3]*c[2] + t[0]*c[1] - t[1]*c[0]);
      p.sat = 0;
      for (int i = 0; i < 3; i++) begin
         neg = r[i] < 0;
         mag = neg ? 64'(-r[i]) : 64'(r[i]);
         lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
         over = 0;
         res = 0;
         if (mag != 0 && len > (64'hFFFF_FFFF_FFFF_FFFF - half) / mag) begin
            over = 1;
         end else begin
            res = (mag * len + half) >> 16;
            if (res > lim) over = 1;
         end
         if (over) begin
            res = lim;
            p.sat = 1;
         end
         outv[i] = neg ? 32'(64'd0 - res) : res[31:0];
      end
      p.x = outv[0]; p.y = outv[1]; p.z = outv[2];
      return p;
   endfunction

   function automatic logic signed [31:0] near(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   function automatic logic signed [31:0] any_word();
      return $signed($urandom());
   endfunction

   task automatic add_item(logic signed [31:0] vx, vy, vz, qx, qy, qz, qw);
      rot_req_type it;
      it.vx = vx; it.vy = vy; it.vz = vz;
      it.qx = qx; it.qy = qy; it.qz = qz; it.qw = qw;
      it.drain = 0;
      pending_items.push_back(it);
   endtask

   // Stimulus
   initial begin
      logic signed [31:0] mn, mx, one;
      int kind;
      mn = 32'sh8000_0000;
      mx = 32'sh7FFF_FFFF;
      one = 32'sh0001_0000;
      // zero quaternion
      add_item(one, -one, mx, 0, 0, 0, 0);
      add_item(mn, mn, mn, 0, 0, 0, 0);
      // identity, quarter turns and a half turn
      add_item(one, 2 * one, 3 * one, 0, 0, 0, one);
      add_item(one, 0, 0, 0, 0, 32'sd46341, 32'sd46341);
      add_item(0, one, 0, 32'sd46341, 0, 0, 32'sd46341);
      add_item(one, one, one, 0, one, 0, 0);
      // extreme components; with every quaternion component at the most negative value the sum of squares is 2^64
      add_item(one, one, one, mn, mn, mn, mn);
      add_item(mx, mn, mx, mn, mn, mn, mn);
      add_item(mx, mx, mx, mx, mx, mx, mx);
      add_item(mn, mn, mn, mx, mn, mx, mn);
      add_item(mx, mn, 0, 0, 0, 0, mx);
      add_item(mn, mx, mn, 0, 0, 0, mn);
      // tiny quaternions
      add_item(one, -one, one, 1, 0, 0, 0);
      add_item(mx, mx, mn, -1, 1, -1, 1);
      add_item(-1, 1, -1, 0, 0, 0, -1);
      // large lengths, with and without saturation
      add_item(mx, mx, mx, 0, 0, 0, 32'sh4000_0000);
      add_item(mn, 0, 0, 0, 0, 0, mn);
      add_item(one, 0, 0, 32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, 32'sh0321_0000);
      add_item(0, 0, 0, mx, mn, one, -one);
      add_item(32'sh7FFF_0000, -32'sh0000_8000, 32'sh0000_8000, one, one, one, one);
      for (int n = 0; n < 900; n++) begin
         kind = $urandom_range(9);
         if (kind < 3)
            add_item(any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word(), any_word());
         else if (kind < 7)
            add_item(near(1 << 22), near(1 << 22), near(1 << 22),
                     near(1 << 17), near(1 << 17), near(1 << 17), near(1 << 17));
         else if (kind < 9)
            add_item(near(1 << 30), near(1 << 30), near(1 << 30),
                     near(1 << 24), near(1 << 24), near(1 << 24), near(1 << 24));
         else
            add_item(any_word(), any_word(), any_word(),
                     near(4), near(4), near(4), near(4));
         if (n == 300 || n == 650) pending_items[pending_items.size() - 1].drain = 1;
      end
      items_loaded = 1;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: bursts and gaps on the request side
   always @(posedge clock) begin
      logic        nv;
      rot_req_type nx;
      cycles <= cycles + 1;
      if (!reset) begin
         nv = req_valid;
         if (req_valid && !req_stall) begin
            expected_rots.push_back(predict_rotation(cur_item));
            nv = 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && (expected_rots.size() > 0 || req_valid))) begin
               nx = pending_items.pop_front();
               nx.drain = 0;
               cur_item <= nx;
               req_vec_x <= nx.vx; req_vec_y <= nx.vy; req_vec_z <= nx.vz;
               req_quat_x <= nx.qx; req_quat_y <= nx.qy;
               req_quat_z <= nx.qz; req_quat_w <= nx.qw;
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(40);
                  gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
               end
            end
         end
         req_valid <= nv;
      end
   end

   // Receiver stall pattern, changing mode now and then
   always @(posedge clock) begin
      if (($urandom_range(63)) == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(1));
         2: rsp_stall <= ($urandom_range(4) != 0);
         default: rsp_stall <= (cycles % 7) < 3;
      endcase
   end

   // Monitor
   always @(posedge clock) begin
      rot_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rots.size() == 0) begin
            $display("%0t: unexpected item x=%h y=%h z=%h sat=%b", $realtime,
                     rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_saturated);
            errors++;
         end else begin
            e = expected_rots.pop_front();
            if (rsp_rot_x !== e.x) begin
               $display("%0t: rot_x expected %h actual %h", $realtime, e.x, rsp_rot_x);
               errors++;
            end
            if (rsp_rot_y !== e.y) begin
               $display("%0t: rot_y expected %h actual %h", $realtime, e.y, rsp_rot_y);
               errors++;
            end
            if (rsp_rot_z !== e.z) begin
               $display("%0t: rot_z expected %h actual %h", $realtime, e.z, rsp_rot_z);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %b actual %b", $realtime, e.sat,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      wait (items_loaded);
      @(posedge clock);
      while (pending_items.size() > 0 || req_valid || expected_rots.size() > 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0 && expected_rots.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
